// ===== hdl/spmv_pkg.sv =====
// shared types and constants for the csr sparse matrix-vector multiply unit
`default_nettype none

package spmv_pkg;

	// stream opcodes
	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_NONZERO = 2'd1,
		OP_EMPTY   = 2'd2,
		OP_UNUSED  = 2'd3
	} opcode_t;

	// register indexes on the apb port
	localparam logic REG_COLUMN_COUNT = 1'b0;
	localparam logic REG_ROW_COUNT    = 1'b1;

	// reset values of the configuration registers
	localparam logic [10:0] COLUMN_COUNT_RESET = 11'd1024;
	localparam logic [15:0] ROW_COUNT_RESET    = 16'd1024;

	// work queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	// saturation limits
	localparam logic signed [31:0] Q16_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;
	localparam logic signed [63:0] ACC_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

	// one classified item waiting for the back end
	typedef struct packed {
		logic               empty_row;
		logic               col_err;
		logic               row_last;
		logic signed [31:0] value;
		logic signed [31:0] vec;
	} work_t;

	// queue status seen by both ends
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

// ===== hdl/spmv_front.sv =====
// front end: accepts stream beats, owns the vector store, classifies items
`default_nettype none

module spmv_front #(
	parameter int unsigned VECTOR_DEPTH = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            opcode,
	input  wire logic [9:0]            index,
	input  wire logic signed [31:0]    value,
	input  wire logic                  row_last,
	input  wire logic [10:0]           column_count,
	output logic                       push,
	output spmv_pkg::work_t            push_item,
	input  wire spmv_pkg::qstat_t      qstat
);

	localparam int unsigned AW = $clog2(VECTOR_DEPTH);

	spmv_pkg::opcode_t  op;
	logic [16:0]        idx_ext;
	logic               in_store;
	logic [AW-1:0]      addr;
	logic               col_err;
	logic               accept;
	logic               take_work;

	logic signed [31:0] mem [VECTOR_DEPTH];

	logic               valid_s1;
	logic               empty_s1;
	logic               err_s1;
	logic               last_s1;
	logic signed [31:0] value_s1;
	logic signed [31:0] vec_s1;

	assign op       = spmv_pkg::opcode_t'(opcode);
	assign idx_ext  = 17'(index);
	assign in_store = idx_ext < 17'(VECTOR_DEPTH);
	assign addr     = idx_ext[AW-1:0];
	assign col_err  = ({1'b0, index} >= column_count) || !in_store;

	assign in_stall  = valid_s1 && qstat.full;
	assign accept    = in_valid && !in_stall;
	assign take_work = accept && (op == spmv_pkg::OP_NONZERO || op == spmv_pkg::OP_EMPTY);
	assign push      = valid_s1 && !qstat.full;

	// vector store, read early so later loads cannot overtake queued nonzeros
	always_ff @(posedge clk) begin
		if (accept && op == spmv_pkg::OP_LOAD && in_store) begin
			mem[addr] <= value;
		end
		if (accept && op == spmv_pkg::OP_NONZERO) begin
			vec_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_work) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_work) begin
			empty_s1 <= (op == spmv_pkg::OP_EMPTY);
			err_s1   <= (op == spmv_pkg::OP_NONZERO) && col_err;
			last_s1  <= row_last;
			value_s1 <= value;
		end
	end

	always_comb begin
		push_item.empty_row = empty_s1;
		push_item.col_err   = err_s1;
		push_item.row_last  = last_s1;
		push_item.value     = value_s1;
		push_item.vec       = vec_s1;
	end

endmodule

`default_nettype wire

// ===== hdl/spmv_queue.sv =====
// short work queue decoupling front and back
`default_nettype none

module spmv_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire spmv_pkg::work_t   push_item,
	input  wire logic              pop,
	output spmv_pkg::work_t        head,
	output spmv_pkg::qstat_t       qstat
);

	spmv_pkg::work_t                 entry_q [spmv_pkg::QUEUE_DEPTH];
	logic [spmv_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [spmv_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [spmv_pkg::QCNT_W-1:0]     count_q;

	assign qstat.full  = count_q == spmv_pkg::QCNT_W'(spmv_pkg::QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;
	assign head        = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("queue written while full");
	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty))
		else $error("queue read while empty");
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spmv_pkg::QCNT_W'(spmv_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");
`endif

endmodule

`default_nettype wire

// ===== hdl/spmv_back.sv =====
// back end: multiply, saturating row accumulation, output conversion
`default_nettype none

module spmv_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire spmv_pkg::work_t   head,
	input  wire spmv_pkg::qstat_t  qstat,
	output logic                   pop,
	input  wire logic [15:0]       row_count,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [15:0]            row_index,
	output logic signed [31:0]     row_sum,
	output logic                   saturated,
	output logic                   column_error
);

	logic               en;

	// s1: operands
	logic               valid_s1;
	logic               empty_s1;
	logic               err_s1;
	logic               last_s1;
	logic signed [31:0] a_s1;
	logic signed [31:0] b_s1;

	// s2: product
	logic               valid_s2;
	logic               empty_s2;
	logic               err_s2;
	logic               last_s2;
	logic signed [63:0] prod_c;
	logic signed [63:0] prod_s2;

	// row state
	logic signed [63:0] acc_q;
	logic               rsat_q;
	logic               rerr_q;

	// s3: finished row
	logic               valid_s3;
	logic signed [63:0] acc_s3;
	logic               sat_s3;
	logic               err_s3;

	logic signed [63:0] sum_w;
	logic               ovf;
	logic signed [63:0] new_acc;

	// conversion and row counter
	logic [47:0]        floor_c;
	logic [48:0]        round_c;
	logic               fits;
	logic signed [31:0] sum_c;
	logic [16:0]        row_next_c;

	logic               out_valid_q;
	logic [15:0]        row_index_q;
	logic signed [31:0] row_sum_q;
	logic               saturated_q;
	logic               column_error_q;
	logic [15:0]        row_cnt_q;

	assign en  = !out_valid_q || !out_stall;
	assign pop = en && !qstat.empty;

	assign prod_c  = a_s1 * b_s1;
	assign sum_w   = acc_q + prod_s2;
	assign ovf     = (acc_q[63] == prod_s2[63]) && (sum_w[63] != acc_q[63]);
	assign new_acc = ovf ? (prod_s2[63] ? spmv_pkg::ACC_MIN : spmv_pkg::ACC_MAX) : sum_w;

	// round half up to q16.16, then clamp
	assign floor_c = acc_s3[63:16];
	assign round_c = {floor_c[47], floor_c} + {48'd0, acc_s3[15]};
	assign fits    = round_c[48:31] == {18{round_c[31]}};
	assign sum_c   = fits ? round_c[31:0] :
		(round_c[48] ? spmv_pkg::Q16_MIN : spmv_pkg::Q16_MAX);

	assign row_next_c = {1'b0, row_cnt_q} + 17'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			rsat_q      <= 1'b0;
			rerr_q      <= 1'b0;
			row_cnt_q   <= '0;
		end else if (en) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2 && (empty_s2 || last_s2);
			out_valid_q <= valid_s3;
			if (valid_s2) begin
				if (empty_s2 || last_s2) begin
					acc_q  <= '0;
					rsat_q <= 1'b0;
					rerr_q <= 1'b0;
				end else begin
					acc_q  <= new_acc;
					rsat_q <= rsat_q || ovf;
					rerr_q <= rerr_q || err_s2;
				end
			end
			if (valid_s3) begin
				row_cnt_q <= (row_next_c >= {1'b0, row_count}) ? '0 : row_next_c[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (pop) begin
				empty_s1 <= head.empty_row;
				err_s1   <= head.col_err;
				last_s1  <= head.row_last;
				a_s1     <= head.value;
				b_s1     <= head.vec;
			end
			empty_s2 <= empty_s1;
			err_s2   <= err_s1;
			last_s2  <= last_s1;
			prod_s2  <= (err_s1 || empty_s1) ? 64'sd0 : prod_c;
			if (empty_s2) begin
				acc_s3 <= '0;
				sat_s3 <= 1'b0;
				err_s3 <= 1'b0;
			end else begin
				acc_s3 <= new_acc;
				sat_s3 <= rsat_q || ovf;
				err_s3 <= rerr_q || err_s2;
			end
			if (valid_s3) begin
				row_index_q    <= row_cnt_q;
				row_sum_q      <= sum_c;
				saturated_q    <= sat_s3 || !fits;
				column_error_q <= err_s3;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign row_index    = row_index_q;
	assign row_sum      = row_sum_q;
	assign saturated    = saturated_q;
	assign column_error = column_error_q;

endmodule

`default_nettype wire

// ===== hdl/csr_sparse_matrix_vector_multiply_unit.sv =====
// top level of the csr sparse matrix times dense vector unit
`default_nettype none

// Streaming CSR sparse matrix-vector multiply. Each input beat is one item:
// a load (opcode load) writes one Q16.16 element of the dense vector into the
// on-chip store, a nonzero multiplies its value by the stored element at its
// column and adds the Q32.32 product into the saturating row accumulator, and
// an empty-row item emits a zero result. A nonzero with row_last set closes the
// row and emits one result beat: row number, the sum rounded half up and
// clamped to Q16.16, a saturation flag and a column error flag (a column at or
// beyond column_count, or beyond the store). The block takes one item every
// clock cycle unless stalled; it is set by the single multiply-accumulate in
// the back end, whose accumulator is updated once per cycle. A row-closing
// nonzero passes the front register, the queue, stages s1, s2, s3 and the
// output register before its result beat. A four-entry work queue sits between
// the front end (vector store and classification) and the back end (multiplier,
// accumulator, output register), so out_stall only reaches in_stall once
// the queue has filled. Vector entries must be loaded before a nonzero reads
// them; the store has no reset. Registers on the apb port: column_count at
// 0x0, row_count at 0x4; write them only while the block is idle.

module csr_sparse_matrix_vector_multiply_unit #(
	parameter int unsigned VECTOR_DEPTH = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// input stream
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         opcode,
	input  wire logic [9:0]         index,
	input  wire logic signed [31:0] value,
	input  wire logic               row_last,
	// result stream
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [15:0]             row_index,
	output logic signed [31:0]      row_sum,
	output logic                    saturated,
	output logic                    column_error
);

	logic [10:0]       column_count_q;
	logic [15:0]       row_count_q;
	logic              cfg_wr;

	logic              push;
	logic              pop;
	spmv_pkg::work_t   push_item;
	spmv_pkg::work_t   head;
	spmv_pkg::qstat_t  qstat;

	// apb: no wait states, word-aligned registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= spmv_pkg::COLUMN_COUNT_RESET;
			row_count_q    <= spmv_pkg::ROW_COUNT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				spmv_pkg::REG_COLUMN_COUNT: column_count_q <= pwdata[10:0];
				spmv_pkg::REG_ROW_COUNT:    row_count_q    <= pwdata[15:0];
				default:                    row_count_q    <= row_count_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			spmv_pkg::REG_COLUMN_COUNT: prdata = {21'd0, column_count_q};
			spmv_pkg::REG_ROW_COUNT:    prdata = {16'd0, row_count_q};
			default:                    prdata = '0;
		endcase
	end

	// front: vector store and item classification
	spmv_front #(
		.VECTOR_DEPTH(VECTOR_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.index        (index),
		.value        (value),
		.row_last     (row_last),
		.column_count (column_count_q),
		.push         (push),
		.push_item    (push_item),
		.qstat        (qstat)
	);

	// work queue
	spmv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	// back: multiply-accumulate and result beat
	spmv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.row_count    (row_count_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.row_index    (row_index),
		.row_sum      (row_sum),
		.saturated    (saturated),
		.column_error (column_error)
	);

endmodule

`default_nettype wire
